### rtl/bdtf_pkg.sv
// shared types, codes and fixed-point helpers for the block dct threshold filter
// no dependencies; used by bdtf_mac and block_dct_threshold_filter_unit
package bdtf_pkg;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_RUN   = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ADDR = 2'd1;
  localparam logic [1:0] ST_SIZE = 2'd2;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_BLOCK  = 2'd2;
  localparam logic [1:0] REG_THRESH = 2'd3;

  localparam logic [6:0] SIDE_MAX = 7'd64;
  localparam logic signed [63:0] COS_STEP = 64'sd1072448455;
  localparam logic [31:0] HALF_ROOT = 32'd759250125;
  localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

  typedef struct packed {
    logic [1:0] opcode;
    logic [5:0] row;
    logic [5:0] col;
    logic [7:0] pixel_in;
  } in_item_t;

  typedef struct packed {
    logic signed [11:0] pixel_out;
    logic [1:0]         status;
  } out_item_t;

  typedef struct packed {
    logic mul_en;
    logic acc_en;
    logic acc_first;
  } mac_ctrl_t;

  typedef logic signed [31:0] cos_tab_t [0:64];

  // round half away from zero, then shift right
  function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v, input int sh);
    logic [63:0] mag;
    logic [63:0] r;
    mag = v[63] ? 64'(-v) : 64'(v);
    r = (mag + (64'd1 << (sh - 1))) >> sh;
    return v[63] ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fff_ffff;
    else if (v < -64'sd2147483648) return 32'sh8000_0000;
    else return $signed(v[31:0]);
  endfunction

  // cos(pi*m/64) in q2.30 from the chebyshev recurrence
  function automatic cos_tab_t build_cos();
    cos_tab_t t;
    logic signed [63:0] c [0:64];
    c[0] = 64'sd1073741824;
    c[1] = COS_STEP;
    for (int m = 1; m < 64; m++) begin
      c[m + 1] = rnd_shift(64'sd2 * COS_STEP * c[m], 30) - c[m - 1];
    end
    for (int m = 0; m < 65; m++) begin
      t[m] = $signed(c[m][31:0]);
    end
    return t;
  endfunction

  localparam cos_tab_t COS_Q30 = build_cos();

endpackage

### rtl/bdtf_mac.sv
// shared multiply-accumulate unit: one registered 32x32 multiply, 64-bit accumulator
// depends on bdtf_pkg
module bdtf_mac import bdtf_pkg::*; (
  input  logic               clk,
  input  mac_ctrl_t          ctrl,
  input  logic signed [31:0] op_a,
  input  logic signed [31:0] op_b,
  output logic signed [63:0] acc
);

  logic signed [63:0] prod;

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) prod <= op_a * op_b;
    if (ctrl.acc_en) acc <= ctrl.acc_first ? prod : acc + prod;
  end

endmodule

### rtl/block_dct_threshold_filter_unit.sv
// block dct threshold filter: pixel stores, transform sequencer, output register
// depends on bdtf_pkg and bdtf_mac
//
// input beats carry an opcode: write pixel, run filter, read filtered pixel.
// every input beat gives exactly one output beat {pixel_out, status}.
// write: result beat registered at the accept edge.
// read: filtered store read port is registered; the result beat follows from S_READ.
// run: the shared multiplier walks every product of the transforms, each product
//   passing S_ISSUE, S_MUL and S_ACC and each stored result S_FIN: cosine rom
//   build, four matrix passes, limit product, threshold sweep, then the result
//   beat; not ready for input meanwhile.
// status 1 flags an address outside the image, status 2 a run with bad sizes.
// reset: registers take their defaults, then a sweep clears all 4096 entries of the
//   filtered store; input is stalled during the sweep, config writes go in.
// the result register holds while out_stall is high; a new input beat is
// taken once the result register is empty or being taken in that cycle.
module block_dct_threshold_filter_unit import bdtf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  input  logic      cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_READ, S_ISSUE, S_MUL, S_ACC, S_FIN
  } state_t;

  typedef enum logic [2:0] {
    P_ROM, P_FWD1, P_FWD2, P_LIMIT, P_THR, P_INV1, P_INV2
  } phase_t;

  state_t state;
  phase_t phase;

  logic [6:0]  img_cols;
  logic [6:0]  img_rows;
  logic [2:0]  block_size_log2;
  logic [15:0] threshold_fraction;

  logic [11:0] clr_addr;
  logic [5:0]  bi, bj, i, j;
  logic [4:0]  k;
  logic [6:0]  ang;
  logic signed [31:0] largest;
  logic [63:0] limit;

  // memories
  logic [7:0]         src_mem  [0:4095];
  logic signed [31:0] coef_mem [0:4095];
  logic signed [11:0] filt_mem [0:4095];
  logic signed [31:0] scr_mem  [0:1023];
  logic signed [16:0] rom_mem  [0:1023];

  logic        src_we, coef_we, filt_we, scr_we, rom_we;
  logic [11:0] src_wa, src_ra, coef_wa, coef_ra, filt_wa, filt_ra;
  logic [9:0]  scr_wa, scr_ra, rom_wa, rom_ra;
  logic [7:0]  src_wd, src_rd;
  logic signed [31:0] coef_wd, coef_rd, scr_wd, scr_rd;
  logic signed [11:0] filt_wd, filt_rd;
  logic signed [16:0] rom_wd, rom_rd;

  logic        accept, addr_ok, run_ok;
  logic [6:0]  ns;
  logic [4:0]  ns_m1;
  logic [4:0]  i5, j5;
  logic [5:0]  row_b, col_b, row_k, col_k;
  logic [10:0] ang_prod;
  logic [6:0]  ang7;
  logic [2:0]  e;
  logic [31:0] scale;
  logic        k_last, j_last, i_last, bj_end, blk_last;

  mac_ctrl_t          mac_ctrl;
  logic signed [31:0] op_a, op_b;
  logic signed [63:0] acc;

  logic signed [31:0] coef_new, u_new, sat_acc;
  logic signed [63:0] rnd45, rnd22, rnd15, rnd23;
  logic signed [11:0] pix_new;
  logic signed [32:0] cx;
  logic [32:0] cmag;
  logic        zero_it;

  function automatic logic [9:0] sq_idx(input logic [4:0] r, input logic [4:0] c,
                                        input logic [2:0] sh);
    return ({5'b0, r} << sh) | {5'b0, c};
  endfunction

  bdtf_mac u_mac (
    .clk  (clk),
    .ctrl (mac_ctrl),
    .op_a (op_a),
    .op_b (op_b),
    .acc  (acc)
  );

  assign accept = in_valid && !in_stall;
  assign in_stall = !(state == S_IDLE && (!out_valid || !out_stall));
  assign addr_ok = ({1'b0, in_data.row} < img_rows) && ({1'b0, in_data.col} < img_cols);

  assign ns = 7'd1 << block_size_log2;
  assign ns_m1 = ns[4:0] - 5'd1;
  assign run_ok = block_size_log2 >= 3'd1 && block_size_log2 <= 3'd5 &&
                  img_cols != 7'd0 && img_rows != 7'd0 &&
                  img_cols <= SIDE_MAX && img_rows <= SIDE_MAX &&
                  (img_cols & (ns - 7'd1)) == 7'd0 &&
                  (img_rows & (ns - 7'd1)) == 7'd0;

  assign i5 = i[4:0];
  assign j5 = j[4:0];
  assign row_b = bi + i;
  assign col_b = bj + j;
  assign row_k = bi + {1'b0, k};
  assign col_k = bj + {1'b0, k};

  // cosine angle index for rom entry (i = frequency, j = sample)
  assign ang_prod = 11'({j5, 1'b1}) * 11'(i5);
  assign ang7 = 7'(ang_prod << (3'd5 - block_size_log2));
  assign e = (i5 == 5'd0) ? block_size_log2 : block_size_log2 - 3'd1;
  assign scale = e[0] ? (HALF_ROOT >> e[2:1]) : (ONE_Q30 >> e[2:1]);

  assign k_last = (phase == P_ROM) || (phase == P_LIMIT) || (k == ns_m1);
  assign j_last = (phase == P_THR) ? ({1'b0, j} == img_cols - 7'd1) : (j5 == ns_m1);
  assign i_last = (phase == P_THR) ? ({1'b0, i} == img_rows - 7'd1) : (i5 == ns_m1);
  assign bj_end = ({1'b0, bj} + ns) == img_cols;
  assign blk_last = bj_end && (({1'b0, bi} + ns) == img_rows);

  // read addresses follow the counters; read data is registered and lands in the next cycle
  always_comb begin
    rom_ra = 10'd0;
    scr_ra = 10'd0;
    coef_ra = {i, j};
    case (phase)
      P_FWD1: rom_ra = sq_idx(i5, k, block_size_log2);
      P_FWD2: begin
        rom_ra = sq_idx(j5, k, block_size_log2);
        scr_ra = sq_idx(i5, k, block_size_log2);
      end
      P_INV1: begin
        rom_ra = sq_idx(k, j5, block_size_log2);
        coef_ra = {row_b, col_k};
      end
      P_INV2: begin
        rom_ra = sq_idx(k, i5, block_size_log2);
        scr_ra = sq_idx(k, j5, block_size_log2);
      end
      default: ;
    endcase
  end
  assign src_ra = {row_k, col_b};
  assign filt_ra = {in_data.row, in_data.col};

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (phase)
      P_ROM: begin
        op_a = $signed(scale);
        op_b = COS_Q30[ang];
      end
      P_FWD1: begin
        op_a = 32'(rom_rd);
        op_b = $signed({24'b0, src_rd});
      end
      P_FWD2: begin
        op_a = scr_rd;
        op_b = 32'(rom_rd);
      end
      P_LIMIT: begin
        op_a = largest;
        op_b = $signed({16'b0, threshold_fraction});
      end
      P_INV1: begin
        op_a = coef_rd;
        op_b = 32'(rom_rd);
      end
      P_INV2: begin
        op_a = 32'(rom_rd);
        op_b = scr_rd;
      end
      default: ;
    endcase
  end

  assign mac_ctrl.mul_en = (state == S_MUL);
  assign mac_ctrl.acc_en = (state == S_ACC);
  assign mac_ctrl.acc_first = (k == 5'd0);

  // finishing arithmetic on the accumulator
  assign rnd45 = rnd_shift(acc, 45);
  assign rnd22 = rnd_shift(acc, 22);
  assign rnd15 = rnd_shift(acc, 15);
  assign rnd23 = rnd_shift(acc, 23);
  assign sat_acc = sat32(acc);
  assign coef_new = sat32(rnd22);
  assign u_new = sat32(rnd15);
  assign pix_new = (rnd23 > 64'sd2047) ? 12'sd2047 :
                   (rnd23 < -64'sd2048) ? 12'sh800 : $signed(rnd23[11:0]);

  assign cx = 33'(coef_rd);
  assign cmag = cx[32] ? 33'(-cx) : 33'(cx);
  assign zero_it = {15'b0, cmag, 16'b0} < limit;

  // write ports
  assign src_we = (state == S_IDLE) && accept && in_data.opcode == OP_WRITE && addr_ok;
  assign src_wa = {in_data.row, in_data.col};
  assign src_wd = in_data.pixel_in;

  assign rom_we = (state == S_FIN) && phase == P_ROM;
  assign rom_wa = sq_idx(i5, j5, block_size_log2);
  assign rom_wd = rnd45[16:0];

  assign scr_we = (state == S_FIN) && (phase == P_FWD1 || phase == P_INV1);
  assign scr_wa = sq_idx(i5, j5, block_size_log2);
  assign scr_wd = (phase == P_FWD1) ? sat_acc : u_new;

  assign coef_we = (state == S_FIN) && (phase == P_FWD2 || (phase == P_THR && zero_it));
  assign coef_wa = (phase == P_FWD2) ? {row_b, col_b} : {i, j};
  assign coef_wd = (phase == P_FWD2) ? coef_new : 32'sd0;

  assign filt_we = (state == S_CLEAR) || ((state == S_FIN) && phase == P_INV2);
  assign filt_wa = (state == S_CLEAR) ? clr_addr : {row_b, col_b};
  assign filt_wd = (state == S_CLEAR) ? 12'sd0 : pix_new;

  always_ff @(posedge clk) begin
    if (src_we) src_mem[src_wa] <= src_wd;
    src_rd <= src_mem[src_ra];
  end

  always_ff @(posedge clk) begin
    if (coef_we) coef_mem[coef_wa] <= coef_wd;
    coef_rd <= coef_mem[coef_ra];
  end

  always_ff @(posedge clk) begin
    if (filt_we) filt_mem[filt_wa] <= filt_wd;
    filt_rd <= filt_mem[filt_ra];
  end

  always_ff @(posedge clk) begin
    if (scr_we) scr_mem[scr_wa] <= scr_wd;
    scr_rd <= scr_mem[scr_ra];
  end

  always_ff @(posedge clk) begin
    if (rom_we) rom_mem[rom_wa] <= rom_wd;
    rom_rd <= rom_mem[rom_ra];
  end

  // sequencer, config registers and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      phase <= P_ROM;
      clr_addr <= '0;
      out_valid <= 1'b0;
      largest <= '0;
      img_cols <= 7'd64;
      img_rows <= 7'd64;
      block_size_log2 <= 3'd3;
      threshold_fraction <= 16'd6554;
      bi <= '0;
      bj <= '0;
      i <= '0;
      j <= '0;
      k <= '0;
    end else begin
      ang <= (ang7 > 7'd64) ? 7'(8'd128 - {1'b0, ang7}) : ang7;

      if (cfg_write) begin
        case (cfg_index)
          REG_WIDTH:  img_cols <= cfg_data[6:0];
          REG_HEIGHT: img_rows <= cfg_data[6:0];
          REG_BLOCK:  block_size_log2 <= cfg_data[2:0];
          REG_THRESH: threshold_fraction <= cfg_data;
          default: ;
        endcase
      end

      if (out_valid && !out_stall) out_valid <= 1'b0;

      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 12'd1;
          if (clr_addr == 12'hfff) state <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            out_data.pixel_out <= 12'sd0;
            out_data.status <= ST_OK;
            case (in_data.opcode)
              OP_WRITE: begin
                out_valid <= 1'b1;
                if (!addr_ok) out_data.status <= ST_ADDR;
              end
              OP_READ: begin
                if (addr_ok) begin
                  state <= S_READ;
                end else begin
                  out_valid <= 1'b1;
                  out_data.status <= ST_ADDR;
                end
              end
              OP_RUN: begin
                if (run_ok) begin
                  state <= S_ISSUE;
                  phase <= P_ROM;
                  largest <= '0;
                  bi <= '0;
                  bj <= '0;
                  i <= '0;
                  j <= '0;
                  k <= '0;
                end else begin
                  out_valid <= 1'b1;
                  out_data.status <= ST_SIZE;
                end
              end
              default: out_valid <= 1'b1;
            endcase
          end
        end
        S_READ: begin
          out_valid <= 1'b1;
          out_data.pixel_out <= filt_rd;
          out_data.status <= ST_OK;
          state <= S_IDLE;
        end
        S_ISSUE: begin
          // threshold sweep needs only the coefficient read
          state <= (phase == P_THR) ? S_FIN : S_MUL;
        end
        S_MUL: begin
          state <= S_ACC;
        end
        S_ACC: begin
          if (k_last) begin
            k <= '0;
            state <= S_FIN;
          end else begin
            k <= k + 5'd1;
            state <= S_ISSUE;
          end
        end
        S_FIN: begin
          state <= S_ISSUE;
          if (phase == P_FWD2 && coef_new > largest) largest <= coef_new;
          if (phase == P_LIMIT) begin
            limit <= acc;
            phase <= P_THR;
            i <= '0;
            j <= '0;
          end else if (!j_last) begin
            j <= j + 6'd1;
          end else begin
            j <= '0;
            if (!i_last) begin
              i <= i + 6'd1;
            end else begin
              i <= '0;
              case (phase)
                P_ROM:  phase <= P_FWD1;
                P_FWD1: phase <= P_FWD2;
                P_FWD2: begin
                  if (blk_last) begin
                    phase <= P_LIMIT;
                    bi <= '0;
                    bj <= '0;
                  end else begin
                    phase <= P_FWD1;
                    if (bj_end) begin
                      bj <= '0;
                      bi <= bi + ns[5:0];
                    end else begin
                      bj <= bj + ns[5:0];
                    end
                  end
                end
                P_THR:  phase <= P_INV1;
                P_INV1: phase <= P_INV2;
                P_INV2: begin
                  if (blk_last) begin
                    state <= S_IDLE;
                    out_valid <= 1'b1;
                    out_data.pixel_out <= 12'sd0;
                    out_data.status <= ST_OK;
                  end else begin
                    phase <= P_INV1;
                    if (bj_end) begin
                      bj <= '0;
                      bi <= bi + ns[5:0];
                    end else begin
                      bj <= bj + ns[5:0];
                    end
                  end
                end
                default: phase <= P_ROM;
              endcase
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
